// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition never holds while out of reset.
`define CHK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: rtl/hsfc_pkg.sv
// Constants and types for the hash/star frame checker.
package hsfc_pkg;

  localparam int STORE_SLOTS = 8;
  localparam int SLOT_IDX_W  = $clog2(STORE_SLOTS);
  localparam int POS_W       = 4;
  localparam int CALC_W      = 11;
  localparam int RXSUM_W     = 16;

  typedef logic [7:0]       byte_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam byte_t START_MARK = 8'h23;
  localparam byte_t TYPE_I     = 8'h49;
  localparam byte_t TYPE_F     = 8'h46;
  localparam byte_t END_MARK   = 8'h2A;
  localparam pos_t  POS_MAX    = 4'd15;
  localparam pos_t  POS_FULL   = 4'd8;
  localparam pos_t  POS_BODY   = 4'd2;
  localparam pos_t  POS_LAST   = 4'd7;

  typedef struct packed {
    logic               sum_ok;
    byte_t              payload_0;
    byte_t              payload_1;
    byte_t              payload_2;
    byte_t              payload_3;
    logic [RXSUM_W-1:0] received_sum;
    logic [CALC_W-1:0]  computed_sum;
  } frame_res_t;

endpackage

// File: rtl/hash_star_frame_checker.sv
// Top level of the hash/star frame checker with a two-entry result buffer.
// Takes a byte per cycle unless stalled; a valid frame's '*' yields a registered result.
// The input stalls only while both the output register and the skid register hold results.
// Throughput is one byte transfer per clock, bounded only by the output buffer occupancy.
// Synchronous active-low reset clears the frame store, fill position, previous byte
// and both result valid flags.
module hash_star_frame_checker
  import hsfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   in_rx_byte,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_sum_ok,
  output logic [7:0]   out_payload_0,
  output logic [7:0]   out_payload_1,
  output logic [7:0]   out_payload_2,
  output logic [7:0]   out_payload_3,
  output logic [15:0]  out_received_sum,
  output logic [10:0]  out_computed_sum
);

`include "assert_macros.svh"

  logic       in_xfer;
  logic       res_vld;
  frame_res_t res;

  logic       out_vld_r, out_vld_nxt;
  frame_res_t out_r, out_nxt;
  logic       skid_vld_r, skid_vld_nxt;
  frame_res_t skid_r, skid_nxt;
  logic       pop;

  assign in_stall = skid_vld_r;
  assign in_xfer  = in_valid && !skid_vld_r;
  assign pop      = out_vld_r && !out_stall;

  hsfc_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_xfer),
    .rx_byte  (in_rx_byte),
    .res_vld  (res_vld),
    .res      (res)
  );

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || pop) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_nxt     = res;
        out_vld_nxt = res_vld;
      end
    end else if (res_vld) begin
      skid_nxt     = res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_sum_ok       = out_r.sum_ok;
  assign out_payload_0    = out_r.payload_0;
  assign out_payload_1    = out_r.payload_1;
  assign out_payload_2    = out_r.payload_2;
  assign out_payload_3    = out_r.payload_3;
  assign out_received_sum = out_r.received_sum;
  assign out_computed_sum = out_r.computed_sum;

  `CHK_NEVER(a_skid_without_out, skid_vld_r && !out_vld_r, "skid holds a result ahead of output")
  `CHK_NEVER(a_result_dropped, res_vld && skid_vld_r, "result produced while buffer is full")
  `CHK_IMPLY(a_skid_fill, $rose(skid_vld_r), $past(out_vld_r && out_stall), "skid filled without stall")

endmodule

// File: rtl/hsfc_frame.sv
// Frame store, fill position and per-byte decode with result generation.
module hsfc_frame
  import hsfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  byte_t      rx_byte,
  output logic       res_vld,
  output frame_res_t res
);

  byte_t store_r   [STORE_SLOTS];
  byte_t store_nxt [STORE_SLOTS];
  pos_t  pos_r, pos_nxt;
  byte_t prev_r, prev_nxt;

  logic              put;
  logic              frame_hit;
  logic [CALC_W-1:0] calc;
  logic [RXSUM_W-1:0] rxsum;

  assign calc = {3'b000, store_r[1]} + {3'b000, store_r[2]} + {3'b000, store_r[3]}
              + {3'b000, store_r[4]} + {3'b000, store_r[5]};
  assign rxsum = {store_r[6], store_r[7]};

  assign frame_hit = (pos_r == POS_FULL) && (store_r[0] == START_MARK)
                   && (store_r[1] == TYPE_I);

  always_comb begin
    store_nxt = store_r;
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    put       = 1'b0;
    res_vld   = 1'b0;
    if (byte_vld) begin
      prev_nxt = rx_byte;
      if (rx_byte == START_MARK) begin
        put = 1'b1;
      end else if (rx_byte inside {TYPE_I, TYPE_F}) begin
        if (prev_r == START_MARK) begin
          store_nxt[0] = START_MARK;
          store_nxt[1] = rx_byte;
          pos_nxt      = POS_BODY;
        end
      end else if (pos_r inside {[POS_BODY:POS_LAST]}) begin
        put = 1'b1;
      end else if (rx_byte == END_MARK) begin
        res_vld = frame_hit;
        pos_nxt = '0;
      end else begin
        put = 1'b1;
      end
      if (put) begin
        if (pos_r < POS_FULL) begin
          store_nxt[pos_r[SLOT_IDX_W-1:0]] = rx_byte;
        end
        if (pos_r < POS_MAX) begin
          pos_nxt = pos_r + 4'd1;
        end
      end
    end
  end

  always_comb begin
    res.sum_ok       = (rxsum == {5'b00000, calc});
    res.payload_0    = store_r[2];
    res.payload_1    = store_r[3];
    res.payload_2    = store_r[4];
    res.payload_3    = store_r[5];
    res.received_sum = rxsum;
    res.computed_sum = calc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      prev_r <= '0;
      for (int i = 0; i < STORE_SLOTS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      store_r <= store_nxt;
    end
  end

endmodule
